// ===== rtl/kwsm_pkg.sv =====
// Shared types, codes and default sizes for the k-way sorted merge block.
package kwsm_pkg;

	localparam int LISTS_DEF = 8;
	localparam int DEPTH_DEF = 16;

	localparam int OP_W  = 2;
	localparam int IDX_W = 3;
	localparam int VAL_W = 32;
	localparam int STS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [STS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_ORDER = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_POP,
		S_POP_WB,
		S_DONE
	} state_t;

endpackage

// ===== rtl/kwsm_ram.sv =====
// Simple dual-port synchronous memory with a registered read port.
module kwsm_ram #(
	parameter int WIDTH   = kwsm_pkg::VAL_W,
	parameter int ENTRIES = kwsm_pkg::LISTS_DEF
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(ENTRIES)-1:0]  waddr,
	input  logic [WIDTH-1:0]            wdata,
	input  logic [$clog2(ENTRIES)-1:0]  raddr,
	output logic [WIDTH-1:0]            rdata
);
	import kwsm_pkg::*;

	logic [WIDTH-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/k_way_sorted_merge.sv =====
// Top level of the k-way sorted merge: list control, head scan and result register.
//
//  Channel  Handshake             Payload
//  input    in_valid / in_stall   operation, list_index, value
//  result   res_valid / res_stall out_value, out_valid, status, all_empty
//
// A push passes through S_PUSH; a clear, a no-op or a pop with every list empty go straight to
// S_DONE; any other pop scans the head of every list through the metadata memory and then
// the element memory, one list a cycle, and writes back in S_POP_WB.
// A stalled result holds in the output register while the next word is taken and worked
// on; that word waits in its final state until the register frees.
// Reset clears the per-list occupancy flags at once; neither memory needs a clearing pass.
module k_way_sorted_merge #(
	parameter int LISTS = kwsm_pkg::LISTS_DEF,
	parameter int DEPTH = kwsm_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [kwsm_pkg::OP_W-1:0]          operation,
	input  logic [kwsm_pkg::IDX_W-1:0]         list_index,
	input  logic signed [kwsm_pkg::VAL_W-1:0]  value,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic signed [kwsm_pkg::VAL_W-1:0]  out_value,
	output logic                               out_valid,
	output logic [kwsm_pkg::STS_W-1:0]         status,
	output logic                               all_empty
);
	import kwsm_pkg::*;

	localparam int LW = $clog2(LISTS);
	localparam int DW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int SW = FW + 1;
	localparam int CW = $clog2(LISTS + 2);
	localparam int MW = VAL_W + FW + DW;
	localparam int EW = LW + DW;

	state_t state_q, state_d;

	op_t                     op_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CW-1:0]           cnt_q;
	logic [LISTS-1:0]        nonempty_q;

	logic                    v_s1, v_s2;
	logic [LW-1:0]           list_s1, list_s2;
	logic [MW-1:0]           meta_s2;

	logic                    found_q;
	logic [LW-1:0]           best_list_q;
	logic signed [VAL_W-1:0] best_val_q;
	logic [MW-1:0]           best_meta_q;

	logic signed [VAL_W-1:0] pend_value_q;
	logic                    pend_flag_q;
	status_t                 pend_status_q;

	logic                    res_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                    out_valid_q;
	status_t                 status_q;
	logic                    all_empty_q;

	logic             meta_we;
	logic [LW-1:0]    meta_waddr, meta_raddr;
	logic [MW-1:0]    meta_wdata, meta_rdata;
	logic             elem_we;
	logic [EW-1:0]    elem_waddr, elem_raddr;
	logic [VAL_W-1:0] elem_wdata, elem_rdata;

	logic                    in_acc, res_free;
	logic [IDX_W+LW-1:0]     in_ext, idx_ext;
	logic [LW-1:0]           in_addr, idx_addr;
	logic                    in_range, ne_push;
	logic [DW-1:0]           rd_rp, cur_rp;
	logic [FW-1:0]           rd_fill, cur_fill, fill_inc;
	logic signed [VAL_W-1:0] rd_last;
	logic                    push_full, push_order, push_ok;
	logic [SW-1:0]           slot_sum;
	logic [DW-1:0]           slot;
	logic signed [VAL_W-1:0] head;
	logic                    take;
	logic [DW-1:0]           b_rp, rp_next;
	logic [FW-1:0]           b_fill, fill_dec;
	logic [VAL_W-1:0]        b_last;
	logic                    last_empty;
	logic                    scan_end;

	kwsm_ram #(.WIDTH(MW), .ENTRIES(LISTS)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	kwsm_ram #(.WIDTH(VAL_W), .ENTRIES(LISTS * (2 ** DW))) u_elem (
		.clk   (clk),
		.we    (elem_we),
		.waddr (elem_waddr),
		.wdata (elem_wdata),
		.raddr (elem_raddr),
		.rdata (elem_rdata)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign res_free  = !res_valid_q || !res_stall;

	assign in_ext    = {{LW{1'b0}}, list_index};
	assign in_addr   = in_ext[LW-1:0];
	assign idx_ext   = {{LW{1'b0}}, idx_q};
	assign idx_addr  = idx_ext[LW-1:0];
	assign in_range  = (32'(idx_q) < LISTS);

	assign rd_rp     = meta_rdata[DW-1:0];
	assign rd_fill   = meta_rdata[DW+FW-1:DW];
	assign rd_last   = signed'(meta_rdata[MW-1:DW+FW]);

	assign ne_push   = in_range && nonempty_q[idx_addr];
	assign cur_rp    = ne_push ? rd_rp : '0;
	assign cur_fill  = ne_push ? rd_fill : '0;
	assign fill_inc  = cur_fill + FW'(1);
	assign push_full  = !in_range || (32'(cur_fill) >= DEPTH);
	assign push_order = ne_push && (val_q < rd_last);
	assign push_ok    = !push_full && !push_order;
	assign slot_sum   = SW'(cur_rp) + SW'(cur_fill);
	assign slot       = (32'(slot_sum) >= DEPTH) ? DW'(slot_sum - SW'(DEPTH)) : DW'(slot_sum);

	assign head      = signed'(elem_rdata);
	assign take      = v_s2 && nonempty_q[list_s2] && (!found_q || (head < best_val_q));
	assign scan_end  = v_s2 && (list_s2 == LW'(LISTS - 1));

	assign b_rp       = best_meta_q[DW-1:0];
	assign b_fill     = best_meta_q[DW+FW-1:DW];
	assign b_last     = best_meta_q[MW-1:DW+FW];
	assign rp_next    = (32'(b_rp) == DEPTH - 1) ? '0 : b_rp + DW'(1);
	assign fill_dec   = b_fill - FW'(1);
	assign last_empty = (b_fill == FW'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (op_t'(operation))
						OP_PUSH:  state_d = S_PUSH;
						OP_POP:   state_d = (|nonempty_q) ? S_POP : S_DONE;
						OP_CLEAR: state_d = S_DONE;
						OP_NOP:   state_d = S_DONE;
					endcase
				end
			end
			S_PUSH: state_d = S_DONE;
			S_POP: begin
				if (scan_end) begin
					state_d = S_POP_WB;
				end
			end
			S_POP_WB: state_d = S_DONE;
			S_DONE: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		meta_raddr = (state_q == S_POP) ? cnt_q[LW-1:0] : in_addr;
		elem_raddr = {list_s1, rd_rp};
		meta_we    = 1'b0;
		meta_waddr = idx_addr;
		meta_wdata = {val_q, fill_inc, cur_rp};
		elem_we    = 1'b0;
		elem_waddr = {idx_addr, slot};
		elem_wdata = val_q;
		unique case (state_q)
			S_PUSH: begin
				meta_we = push_ok;
				elem_we = push_ok;
			end
			S_POP_WB: begin
				meta_we    = !last_empty;
				meta_waddr = best_list_q;
				meta_wdata = {b_last, fill_dec, rp_next};
			end
			default: begin
				meta_we = 1'b0;
				elem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nonempty_q  <= '0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == S_POP) && (32'(cnt_q) < LISTS);
			v_s2    <= v_s1;
			if (in_acc) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				if (op_t'(operation) == OP_CLEAR) begin
					nonempty_q <= '0;
				end
			end
			if (state_q == S_POP) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (state_q == S_PUSH && push_ok) begin
				nonempty_q[idx_addr] <= 1'b1;
			end
			if (state_q == S_POP_WB && last_empty) begin
				nonempty_q[best_list_q] <= 1'b0;
			end
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		list_s1 <= cnt_q[LW-1:0];
		list_s2 <= list_s1;
		meta_s2 <= meta_rdata;
		if (in_acc) begin
			op_q          <= op_t'(operation);
			idx_q         <= list_index;
			val_q         <= value;
			pend_value_q  <= '0;
			pend_flag_q   <= 1'b0;
			pend_status_q <= (op_t'(operation) == OP_POP && !(|nonempty_q)) ?
			                 STAT_EMPTY : STAT_OK;
		end
		if (state_q == S_PUSH && op_q == OP_PUSH) begin
			pend_status_q <= push_full ? STAT_FULL : (push_order ? STAT_ORDER : STAT_OK);
		end
		if (take) begin
			best_list_q <= list_s2;
			best_val_q  <= head;
			best_meta_q <= meta_s2;
		end
		if (state_q == S_POP_WB) begin
			pend_value_q  <= best_val_q;
			pend_flag_q   <= 1'b1;
			pend_status_q <= STAT_OK;
		end
		if (state_q == S_DONE && res_free) begin
			out_value_q <= pend_value_q;
			out_valid_q <= pend_flag_q;
			status_q    <= pend_status_q;
			all_empty_q <= !(|nonempty_q);
		end
	end

	assign res_valid = res_valid_q;
	assign out_value = out_value_q;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign all_empty = all_empty_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for k_way_sorted_merge: a directed table, then random push, pop, clear and no-op traffic.
module tb;
	import kwsm_pkg::*;

	localparam int N_LISTS = LISTS_DEF;
	localparam int N_DEPTH = DEPTH_DEF;
	localparam int N_DIRECTED = 25;
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	typedef struct packed {
		logic signed [VAL_W-1:0] pop_value;
		logic popped;
		status_t code;
		logic drained;
	} merge_result_t;

	typedef struct packed {
		op_t op;
		logic [IDX_W-1:0] idx;
		logic signed [VAL_W-1:0] val;
		int reps;
		bit typed;
		merge_result_t want;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] operation = OP_NOP;
	logic [IDX_W-1:0] list_index = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [VAL_W-1:0] out_value;
	logic out_valid;
	logic [STS_W-1:0] status;
	logic all_empty;

	logic signed [VAL_W-1:0] list_data [N_LISTS][N_DEPTH];
	logic signed [VAL_W-1:0] list_last [N_LISTS];
	int list_head [N_LISTS];
	int list_fill [N_LISTS];
	merge_result_t pending_results [$];

	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off_req = 1'b0;

	step_row_t directed_steps [N_DIRECTED] = '{
		'{OP_POP,   3'd0, 32'sd0,   1,  1'b1, '{32'sd0, 1'b0, STAT_EMPTY, 1'b1}},
		'{OP_PUSH,  3'd0, VAL_MIN,  1,  1'b1, '{32'sd0, 1'b0, STAT_OK, 1'b0}},
		'{OP_PUSH,  3'd0, VAL_MIN,  1,  1'b1, '{32'sd0, 1'b0, STAT_OK, 1'b0}},
		'{OP_PUSH,  3'd0, -32'sd5,  1,  1'b0, '0},
		'{OP_PUSH,  3'd0, -32'sd6,  1,  1'b1, '{32'sd0, 1'b0, STAT_ORDER, 1'b0}},
		'{OP_PUSH,  3'd7, VAL_MAX,  1,  1'b1, '{32'sd0, 1'b0, STAT_OK, 1'b0}},
		'{OP_PUSH,  3'd7, 32'sd0,   1,  1'b1, '{32'sd0, 1'b0, STAT_ORDER, 1'b0}},
		'{OP_PUSH,  3'd3, 32'sd0,   1,  1'b0, '0},
		'{OP_PUSH,  3'd3, -32'sd1,  1,  1'b0, '0},
		'{OP_NOP,   3'd0, 32'sd0,   1,  1'b1, '{32'sd0, 1'b0, STAT_OK, 1'b0}},
		'{OP_POP,   3'd0, 32'sd0,   1,  1'b1, '{VAL_MIN, 1'b1, STAT_OK, 1'b0}},
		'{OP_POP,   3'd0, 32'sd0,   1,  1'b1, '{VAL_MIN, 1'b1, STAT_OK, 1'b0}},
		'{OP_POP,   3'd0, 32'sd0,   1,  1'b0, '0},
		'{OP_POP,   3'd0, 32'sd0,   1,  1'b0, '0},
		'{OP_POP,   3'd0, 32'sd0,   1,  1'b0, '0},
		'{OP_POP,   3'd0, 32'sd0,   1,  1'b1, '{32'sd0, 1'b0, STAT_EMPTY, 1'b1}},
		'{OP_PUSH,  3'd5, 32'sd7,   1,  1'b0, '0},
		'{OP_CLEAR, 3'd0, 32'sd0,   1,  1'b1, '{32'sd0, 1'b0, STAT_OK, 1'b1}},
		'{OP_PUSH,  3'd5, 32'sd3,   1,  1'b1, '{32'sd0, 1'b0, STAT_OK, 1'b0}},
		'{OP_PUSH,  3'd5, 32'sd3,   15, 1'b0, '0},
		'{OP_PUSH,  3'd5, 32'sd3,   1,  1'b1, '{32'sd0, 1'b0, STAT_FULL, 1'b0}},
		'{OP_PUSH,  3'd5, VAL_MIN,  1,  1'b1, '{32'sd0, 1'b0, STAT_FULL, 1'b0}},
		'{OP_POP,   3'd0, 32'sd0,   1,  1'b0, '0},
		'{OP_PUSH,  3'd5, 32'sd2,   1,  1'b1, '{32'sd0, 1'b0, STAT_ORDER, 1'b0}},
		'{OP_CLEAR, 3'd0, 32'sd0,   1,  1'b1, '{32'sd0, 1'b0, STAT_OK, 1'b1}}
	};

	k_way_sorted_merge #(
		.LISTS(N_LISTS),
		.DEPTH(N_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.list_index(list_index),
		.value(value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_value(out_value),
		.out_valid(out_valid),
		.status(status),
		.all_empty(all_empty)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("k_way_sorted_merge regression: fail");
		$finish;
	end

	function automatic merge_result_t apply_list_op(input op_t op, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] val);
		merge_result_t r;
		int best;
		logic signed [VAL_W-1:0] head;
		r = '{pop_value: '0, popped: 1'b0, code: STAT_OK, drained: 1'b1};
		best = -1;
		case (op)
		OP_PUSH: begin
			if (int'(idx) >= N_LISTS || list_fill[idx] >= N_DEPTH) begin
				r.code = STAT_FULL;
			end else if (list_fill[idx] != 0 && val < list_last[idx]) begin
				r.code = STAT_ORDER;
			end else begin
				list_data[idx][(list_head[idx] + list_fill[idx]) % N_DEPTH] = val;
				list_last[idx] = val;
				list_fill[idx]++;
			end
		end
		OP_POP: begin
			for (int i = 0; i < N_LISTS; i++) begin
				if (list_fill[i] != 0) begin
					head = list_data[i][list_head[i]];
					if (best < 0 || head < r.pop_value) begin
						best = i;
						r.pop_value = head;
					end
				end
			end
			if (best < 0) begin
				r.code = STAT_EMPTY;
			end else begin
				r.popped = 1'b1;
				list_head[best] = (list_head[best] + 1) % N_DEPTH;
				list_fill[best]--;
			end
		end
		OP_CLEAR: begin
			for (int i = 0; i < N_LISTS; i++) begin
				list_fill[i] = 0;
				list_head[i] = 0;
			end
		end
		default: begin
		end
		endcase
		for (int i = 0; i < N_LISTS; i++) begin
			if (list_fill[i] != 0) r.drained = 1'b0;
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < 50) $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		mismatch_count++;
	endtask

	task automatic send_word(input op_t op, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] val, input bit typed, input merge_result_t want);
		merge_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		list_index <= idx;
		value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = apply_list_op(op, idx, val);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic run_random(input int count);
		int push_pct, list_lo, list_hi, pick;
		longint nxt;
		op_t op;
		logic [IDX_W-1:0] idx;
		logic signed [VAL_W-1:0] val;
		push_pct = 50;
		list_lo = 0;
		list_hi = N_LISTS - 1;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				push_pct = $urandom_range(1) ? 80 : 25;
				if ($urandom_range(1)) begin
					list_lo = $urandom_range(N_LISTS - 1);
					list_hi = list_lo;
				end else begin
					list_lo = 0;
					list_hi = N_LISTS - 1;
				end
			end
			idx = IDX_W'($urandom_range(list_hi, list_lo));
			val = $urandom;
			pick = $urandom_range(99);
			if (pick < 2) begin
				op = OP_CLEAR;
			end else if (pick < 5) begin
				op = OP_NOP;
			end else if ($urandom_range(99) >= push_pct) begin
				op = OP_POP;
			end else begin
				op = OP_PUSH;
				if (list_fill[idx] == 0) begin
					pick = $urandom_range(7);
					if (pick == 0) val = VAL_MIN;
					else if (pick == 1) val = VAL_MAX;
					else if (pick == 2) val = $signed($urandom_range(20)) - 10;
				end else if ($urandom_range(9) == 0) begin
					nxt = longint'(list_last[idx]) - 1 - $urandom_range(1000);
					if (nxt < longint'(VAL_MIN)) nxt = longint'(VAL_MIN);
					val = nxt[VAL_W-1:0];
				end else begin
					nxt = longint'(list_last[idx]);
					if ($urandom_range(3) != 0) nxt += $urandom_range(1 << $urandom_range(24));
					if (nxt > longint'(VAL_MAX)) nxt = longint'(VAL_MAX);
					val = nxt[VAL_W-1:0];
				end
			end
			send_word(op, idx, val, 1'b0, '0);
		end
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		merge_result_t exp_r;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result word with nothing pending", 1, 0);
			end else begin
				exp_r = pending_results.pop_front();
				if (out_value !== exp_r.pop_value)
					flag_mismatch("out_value", longint'(out_value),
						longint'(exp_r.pop_value));
				if (out_valid !== exp_r.popped)
					flag_mismatch("out_valid", longint'(out_valid), longint'(exp_r.popped));
				if (status !== exp_r.code)
					flag_mismatch("status", longint'(status), longint'(exp_r.code));
				if (all_empty !== exp_r.drained)
					flag_mismatch("all_empty", longint'(all_empty), longint'(exp_r.drained));
			end
		end
	end

	initial begin
		for (int i = 0; i < N_LISTS; i++) begin
			list_head[i] = 0;
			list_fill[i] = 0;
			list_last[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 18;
		recv_idle_pct = 69;
		for (int r = 0; r < N_DIRECTED; r++) begin
			for (int k = 0; k < directed_steps[r].reps; k++) begin
				send_word(directed_steps[r].op, directed_steps[r].idx, directed_steps[r].val,
					directed_steps[r].typed, directed_steps[r].want);
			end
		end
		run_random(500);
		send_idle_pct = 69;
		recv_idle_pct = 18;
		run_random(500);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_req = 1'b1;
		run_random(500);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (N_LISTS + 10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("k_way_sorted_merge regression: pass");
		end else begin
			$display("k_way_sorted_merge regression: fail");
		end
		$finish;
	end

endmodule
